// File: rtl/p2hcr_pkg.sv
// Shared widths, register map and reset values for the pixel-to-cube-hex converter.
package p2hcr_pkg;

    localparam int PIX_W         = 12;
    localparam int ORIGIN_W      = 12;
    localparam int SIZE_W        = 16;
    localparam int COEF_W        = 16;
    localparam int QR_W          = 15;
    localparam int S_W           = 16;
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 5;

    localparam int FRAC_BITS     = 12;
    localparam int COEF_FRAC     = 14;
    localparam int SIZE_FRAC     = 8;
    localparam int SCALE_BITS    = SIZE_FRAC + FRAC_BITS;
    localparam int MIN_SIZE      = 256;
    localparam int MIN_SIZE_LOG2 = 8;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_RADIUS   = 3'd2;
    localparam logic [2:0] REG_COEF_QX  = 3'd3;
    localparam logic [2:0] REG_COEF_QY  = 3'd4;
    localparam logic [2:0] REG_COEF_RX  = 3'd5;
    localparam logic [2:0] REG_COEF_RY  = 3'd6;

    localparam logic [ORIGIN_W-1:0]      RST_ORIGIN_X = '0;
    localparam logic [ORIGIN_W-1:0]      RST_ORIGIN_Y = '0;
    localparam logic [SIZE_W-1:0]        RST_RADIUS   = 16'd8192;
    localparam logic signed [COEF_W-1:0] RST_COEF_QX  = 16'sd9459;
    localparam logic signed [COEF_W-1:0] RST_COEF_QY  = -16'sd5461;
    localparam logic signed [COEF_W-1:0] RST_COEF_RX  = 16'sd0;
    localparam logic signed [COEF_W-1:0] RST_COEF_RY  = 16'sd10923;

endpackage

// File: rtl/pixel_to_hex_cube_round_top.sv
// Pixel position to rounded cube hex coordinates, fully pipelined.
//
// Usage:
//   Input channel: drive i_pixel_x / i_pixel_y with i_start high; the beat is
//   taken at any edge where i_start is high and o_busy is low. o_busy never
//   rises, so one beat can enter on every clock.
//   Output channel: o_valid pulses for one cycle with o_cube_q/r/s; the
//   receiver cannot stall and must take the beat in that cycle.
//   Throughput: one beat per cycle. The pipeline is made of the two restoring
//   dividers (offset / hex size), which produce one quotient bit per stage,
//   COORD_BITS + 12 stages, behind the offset register and followed by a
//   multiply stage, two add stages, a rounding stage and the output register.
//   Configuration: APB write registers origin_x, origin_y, hex size, coef_qx,
//   coef_qy, coef_rx, coef_ry at byte addresses 0x00..0x18; write them only
//   while the pipeline is empty. pready is tied high.
//   Reset: synchronous, active low; clears the pipeline valid bits and loads
//   the default registers (origin 0, size 32.0, pointy-top inverse matrix).
module pixel_to_hex_cube_round_top #(
    parameter int COORD_BITS = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic [p2hcr_pkg::PIX_W-1:0]           i_pixel_x,
    input  logic [p2hcr_pkg::PIX_W-1:0]           i_pixel_y,
    output logic                                  o_valid,
    output logic signed [p2hcr_pkg::QR_W-1:0]     o_cube_q,
    output logic signed [p2hcr_pkg::QR_W-1:0]     o_cube_r,
    output logic signed [p2hcr_pkg::S_W-1:0]      o_cube_s,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [p2hcr_pkg::ADDR_W-1:0]          paddr,
    input  logic [p2hcr_pkg::DATA_W-1:0]          pwdata,
    output logic [p2hcr_pkg::DATA_W-1:0]          prdata,
    output logic                                  pready
);
    import p2hcr_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int EW    = COORD_BITS + PIX_W;
    localparam int QW    = COORD_BITS + SCALE_BITS - MIN_SIZE_LOG2;
    localparam int UW    = QW + 1;
    localparam int PW    = COEF_W + UW;
    localparam int FW    = PW + 1 - COEF_FRAC;
    localparam int SW    = FW + 1;
    localparam int MW    = SW - FRAC_BITS + 1;
    localparam int RW    = MW + 1;
    localparam int CW    = RW + 1;
    localparam int ERR_W = FRAC_BITS + 1;

    localparam logic signed [CW-1:0] Q_HI = CW'((2 ** (QR_W - 1)) - 1);
    localparam logic signed [CW-1:0] Q_LO = ~Q_HI;
    localparam logic signed [CW-1:0] S_HI = CW'((2 ** (S_W - 1)) - 1);
    localparam logic signed [CW-1:0] S_LO = ~S_HI;

    // ---------------------------------------------------------------- config
    logic [ORIGIN_W-1:0]      r_origin_x;
    logic [ORIGIN_W-1:0]      r_origin_y;
    logic [SIZE_W-1:0]        r_radius;
    logic signed [COEF_W-1:0] r_coef_qx;
    logic signed [COEF_W-1:0] r_coef_qy;
    logic signed [COEF_W-1:0] r_coef_rx;
    logic signed [COEF_W-1:0] r_coef_ry;
    logic                     cfg_wr;
    logic [2:0]               cfg_idx;
    logic [SIZE_W-1:0]        size_eff;

    assign pready  = 1'b1;
    assign o_busy  = 1'b0;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= RST_ORIGIN_X;
            r_origin_y <= RST_ORIGIN_Y;
            r_radius   <= RST_RADIUS;
            r_coef_qx  <= RST_COEF_QX;
            r_coef_qy  <= RST_COEF_QY;
            r_coef_rx  <= RST_COEF_RX;
            r_coef_ry  <= RST_COEF_RY;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ORIGIN_X: r_origin_x <= pwdata[ORIGIN_W-1:0];
                REG_ORIGIN_Y: r_origin_y <= pwdata[ORIGIN_W-1:0];
                REG_RADIUS:   r_radius   <= pwdata[SIZE_W-1:0];
                REG_COEF_QX:  r_coef_qx  <= pwdata[COEF_W-1:0];
                REG_COEF_QY:  r_coef_qy  <= pwdata[COEF_W-1:0];
                REG_COEF_RX:  r_coef_rx  <= pwdata[COEF_W-1:0];
                REG_COEF_RY:  r_coef_ry  <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ORIGIN_X: prdata = DATA_W'(r_origin_x);
            REG_ORIGIN_Y: prdata = DATA_W'(r_origin_y);
            REG_RADIUS:   prdata = DATA_W'(r_radius);
            REG_COEF_QX:  prdata = DATA_W'($unsigned(r_coef_qx));
            REG_COEF_QY:  prdata = DATA_W'($unsigned(r_coef_qy));
            REG_COEF_RX:  prdata = DATA_W'($unsigned(r_coef_rx));
            REG_COEF_RY:  prdata = DATA_W'($unsigned(r_coef_ry));
            default:      prdata = '0;
        endcase
    end

    // clamp tiny sizes so the quotient stays within QW bits
    assign size_eff = (r_radius < SIZE_W'(MIN_SIZE)) ? SIZE_W'(MIN_SIZE) : r_radius;

    // ---------------------------------------------------- stage 0: offsets
    // lane 0 is x, lane 1 is y
    logic [PIX_W-1:0]    pix_in  [0:1];
    logic [ORIGIN_W-1:0] orig_in [0:1];

    logic              r_vld [0:QW];
    logic [SIZE_W-1:0] r_rem [0:1][0:QW];
    logic [QW-1:0]     r_quo [0:1][0:QW];
    logic [C-1:0]      r_mag [0:1][0:QW];
    logic              r_neg [0:1][0:QW];

    assign pix_in[0]  = i_pixel_x;
    assign pix_in[1]  = i_pixel_y;
    assign orig_in[0] = r_origin_x;
    assign orig_in[1] = r_origin_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_start & ~o_busy;
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane_in
        logic [EW-1:0] pix_ext;
        logic [EW-1:0] org_ext;
        logic [C:0]    diff;
        logic [C:0]    diff_neg;
        logic [C-1:0]  mag;

        assign pix_ext  = EW'(pix_in[l]);
        assign org_ext  = EW'(orig_in[l]);
        assign diff     = {1'b0, pix_ext[C-1:0]} - {1'b0, org_ext[C-1:0]};
        assign diff_neg = -diff;
        assign mag      = diff[C] ? diff_neg[C-1:0] : diff[C-1:0];

        always_ff @(posedge i_clk) begin
            r_mag[l][0] <= mag;
            r_neg[l][0] <= diff[C];
            // top bits of |d| << SCALE_BITS are below the minimum size
            r_rem[l][0] <= SIZE_W'(mag[C-1 -: MIN_SIZE_LOG2]);
            r_quo[l][0] <= '0;
        end
    end

    // ------------------------------------- divider: one quotient bit a stage
    for (genvar s = 1; s <= QW; s++) begin : g_div
        localparam int P = QW - s;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic          bit_in;
            logic [SIZE_W:0] trial;
            logic [SIZE_W:0] diff;
            logic          take;

            if (P >= SCALE_BITS) begin : g_data_bit
                assign bit_in = r_mag[l][s-1][P-SCALE_BITS];
            end else begin : g_zero_bit
                assign bit_in = 1'b0;
            end

            assign trial = {r_rem[l][s-1], bit_in};
            assign diff  = trial - {1'b0, size_eff};
            assign take  = (trial >= {1'b0, size_eff});

            always_ff @(posedge i_clk) begin
                r_rem[l][s] <= take ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
                r_quo[l][s] <= {r_quo[l][s-1][QW-2:0], take};
                r_mag[l][s] <= r_mag[l][s-1];
                r_neg[l][s] <= r_neg[l][s-1];
            end
        end
    end

    // ----------------------------------------------- multiply by the matrix
    logic signed [UW-1:0] u_val [0:1];
    logic                 r_vld_mul;
    logic signed [PW-1:0] r_p_qx;
    logic signed [PW-1:0] r_p_qy;
    logic signed [PW-1:0] r_p_rx;
    logic signed [PW-1:0] r_p_ry;

    for (genvar l = 0; l < 2; l++) begin : g_sign
        logic signed [UW-1:0] u_pos;

        assign u_pos    = $signed({1'b0, r_quo[l][QW]});
        // truncate toward zero: apply the sign to the magnitude quotient
        assign u_val[l] = r_neg[l][QW] ? -u_pos : u_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_mul <= 1'b0;
        end else begin
            r_vld_mul <= r_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_qx <= r_coef_qx * u_val[0];
        r_p_qy <= r_coef_qy * u_val[1];
        r_p_rx <= r_coef_rx * u_val[0];
        r_p_ry <= r_coef_ry * u_val[1];
    end

    // ---------------------------------------------- sum and floor shift
    logic signed [PW:0]   sum_q;
    logic signed [PW:0]   sum_r;
    logic                 r_vld_sum;
    logic signed [FW-1:0] r_qf;
    logic signed [FW-1:0] r_rf;

    assign sum_q = (PW+1)'(r_p_qx) + (PW+1)'(r_p_qy);
    assign sum_r = (PW+1)'(r_p_rx) + (PW+1)'(r_p_ry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_sum <= 1'b0;
        end else begin
            r_vld_sum <= r_vld_mul;
        end
    end

    // dropping the low bits of a two's complement value rounds toward -inf
    always_ff @(posedge i_clk) begin
        r_qf <= sum_q[PW:COEF_FRAC];
        r_rf <= sum_r[PW:COEF_FRAC];
    end

    // ----------------------------------------------------- form s = -q - r
    logic                 r_vld_frac;
    logic signed [SW-1:0] r_frac [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_frac <= 1'b0;
        end else begin
            r_vld_frac <= r_vld_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frac[0] <= SW'(r_qf);
        r_frac[1] <= SW'(r_rf);
        r_frac[2] <= -SW'(r_qf) - SW'(r_rf);
    end

    // ------------------------------------ round half away, rounding error
    logic                    r_vld_rnd;
    logic signed [RW-1:0]    r_rnd [0:2];
    logic [ERR_W-1:0]        r_err [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_rnd <= 1'b0;
        end else begin
            r_vld_rnd <= r_vld_frac;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_round
        logic                 neg;
        logic [SW-1:0]        mag;
        logic [SW:0]          m_round;
        logic [MW-1:0]        m_int;
        logic signed [RW-1:0] m_pos;
        logic [ERR_W-1:0]     err;

        assign neg     = r_frac[c][SW-1];
        assign mag     = neg ? SW'(-r_frac[c]) : SW'(r_frac[c]);
        assign m_round = {1'b0, mag} + (SW+1)'(2 ** (FRAC_BITS - 1));
        assign m_int   = m_round[SW:FRAC_BITS];
        assign m_pos   = $signed({1'b0, m_int});
        // rounded up when the fraction is at least one half
        assign err     = mag[FRAC_BITS-1]
                       ? ERR_W'(2 ** FRAC_BITS) - {1'b0, mag[FRAC_BITS-1:0]}
                       : {1'b0, mag[FRAC_BITS-1:0]};

        always_ff @(posedge i_clk) begin
            r_rnd[c] <= neg ? -m_pos : m_pos;
            r_err[c] <= err;
        end
    end

    // ------------------------------- fix the worst component, saturate, drive
    function automatic logic signed [CW-1:0] clamp(
        input logic signed [CW-1:0] x,
        input logic signed [CW-1:0] hi,
        input logic signed [CW-1:0] lo
    );
        logic signed [CW-1:0] y;
        if (x > hi) begin
            y = hi;
        end else if (x < lo) begin
            y = lo;
        end else begin
            y = x;
        end
        return y;
    endfunction

    logic signed [CW-1:0] ext_q;
    logic signed [CW-1:0] ext_r;
    logic signed [CW-1:0] ext_s;
    logic signed [CW-1:0] sel_q;
    logic signed [CW-1:0] sel_r;
    logic signed [CW-1:0] sel_s;
    logic signed [CW-1:0] sat_q;
    logic signed [CW-1:0] sat_r;
    logic signed [CW-1:0] sat_s;
    logic                 fix_q;
    logic                 fix_r;

    logic                    r_out_vld;
    logic signed [QR_W-1:0]  r_cube_q;
    logic signed [QR_W-1:0]  r_cube_r;
    logic signed [S_W-1:0]   r_cube_s;

    assign ext_q = CW'(r_rnd[0]);
    assign ext_r = CW'(r_rnd[1]);
    assign ext_s = CW'(r_rnd[2]);

    // strict compares: ties fall through to r, then to s
    assign fix_q = (r_err[0] > r_err[1]) && (r_err[0] > r_err[2]);
    assign fix_r = !fix_q && (r_err[1] > r_err[2]);

    assign sel_q = fix_q ? -ext_r - ext_s : ext_q;
    assign sel_r = fix_r ? -ext_q - ext_s : ext_r;
    assign sel_s = (!fix_q && !fix_r) ? -ext_q - ext_r : ext_s;

    assign sat_q = clamp(sel_q, Q_HI, Q_LO);
    assign sat_r = clamp(sel_r, Q_HI, Q_LO);
    assign sat_s = clamp(sel_s, S_HI, S_LO);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cube_q <= sat_q[QR_W-1:0];
        r_cube_r <= sat_r[QR_W-1:0];
        r_cube_s <= sat_s[S_W-1:0];
    end

    assign o_valid  = r_out_vld;
    assign o_cube_q = r_cube_q;
    assign o_cube_r = r_cube_r;
    assign o_cube_s = r_cube_s;

endmodule
